// ----- rtl/stsq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stsq_pkg;

  localparam int unsigned PosW   = 8;
  localparam int unsigned TimerW = 9;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [TimerW-1:0] WaitPowerOn  = TimerW'(300);
  localparam logic [TimerW-1:0] WaitPowerOff = TimerW'(500);

  typedef enum logic [CmdW-1:0] {
    CMD_TICK       = 3'd0,
    CMD_REQUEST    = 3'd1,
    CMD_INIT       = 3'd2,
    CMD_ENTER_PROG = 3'd3,
    CMD_LEAVE_PROG = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MOT_CLOSED   = 2'd0,
    MOT_THROWN   = 2'd1,
    MOT_CLOSING  = 2'd2,
    MOT_THROWING = 2'd3
  } motion_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_POSITION   = 3'd0,
    REG_END_POSITION     = 3'd1,
    REG_STEP_INTERVAL    = 3'd2,
    REG_INVERT_OPERATION = 3'd3,
    REG_INVERT_POWER     = 3'd4,
    REG_INVERT_FROG      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PosW-1:0] start_position;
    logic [PosW-1:0] end_position;
    logic [PosW-1:0] step_interval;
    logic            invert_operation;
    logic            invert_power;
    logic            invert_frog;
  } stsq_cfg_t;

  typedef struct packed {
    motion_t           motion;
    logic [PosW-1:0]   position;
    logic [TimerW-1:0] wait_timer;
    logic              power_on;
    logic              frog;
  } stsq_state_t;

  typedef struct packed {
    logic [PosW-1:0] servo_position;
    logic            servo_enabled;
    logic            power_level;
    logic            frog_level;
    motion_t         motion_code;
    logic            reported_active;
    logic            arrived;
    logic            request_taken;
  } stsq_result_t;

endpackage

`default_nettype wire

// ----- rtl/stsq_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stsq_step import stsq_pkg::*; (
  input  wire logic [CmdW-1:0] cmd,
  input  wire logic            requested_active,
  input  wire stsq_cfg_t       cfg,
  input  wire stsq_state_t     st,
  output stsq_state_t          st_nxt,
  output stsq_result_t         res
);

  logic [TimerW-1:0] timer_dec;
  logic              to_thrown;
  logic [PosW-1:0]   goal;
  logic              want;
  logic              goal_thrown;
  logic              settled;
  logic              arrived;
  logic              taken;

  assign timer_dec   = (st.wait_timer != '0) ? st.wait_timer - TimerW'(1) : '0;
  assign to_thrown   = (st.motion == MOT_THROWING);
  assign goal        = to_thrown ? cfg.end_position : cfg.start_position;
  assign want        = requested_active ^ cfg.invert_operation;
  assign goal_thrown = (st.motion == MOT_THROWN) || (st.motion == MOT_THROWING);
  assign settled     = (st.motion == MOT_CLOSED) || (st.motion == MOT_THROWN);

  always_comb begin
    st_nxt  = st;
    arrived = 1'b0;
    taken   = 1'b0;
    case (cmd)
      CMD_TICK: begin
        st_nxt.wait_timer = timer_dec;
        if (settled) begin
          if (st.power_on && (timer_dec == '0)) begin
            st_nxt.power_on = 1'b0;
          end
        end else if (st.position == goal) begin
          st_nxt.wait_timer = WaitPowerOff;
          st_nxt.motion     = to_thrown ? MOT_THROWN : MOT_CLOSED;
          st_nxt.frog       = to_thrown ^ cfg.invert_frog;
          arrived           = 1'b1;
        end else if (timer_dec == '0) begin
          st_nxt.position   = to_thrown ? st.position + PosW'(1) : st.position - PosW'(1);
          st_nxt.wait_timer = {1'b0, cfg.step_interval};
        end
      end
      CMD_REQUEST: begin
        if (want != goal_thrown) begin
          st_nxt.power_on   = 1'b1;
          st_nxt.wait_timer = WaitPowerOn;
          st_nxt.motion     = want ? MOT_THROWING : MOT_CLOSING;
          taken             = 1'b1;
        end
      end
      CMD_INIT: begin
        st_nxt.position   = want ? cfg.end_position : cfg.start_position;
        st_nxt.power_on   = 1'b1;
        st_nxt.wait_timer = WaitPowerOn;
        st_nxt.motion     = want ? MOT_THROWING : MOT_CLOSING;
      end
      CMD_ENTER_PROG: begin
        st_nxt.motion     = MOT_THROWN;
        st_nxt.power_on   = 1'b1;
        st_nxt.wait_timer = WaitPowerOn;
      end
      CMD_LEAVE_PROG: begin
        st_nxt.motion     = MOT_CLOSING;
        st_nxt.power_on   = 1'b1;
        st_nxt.wait_timer = WaitPowerOn;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.servo_position  = st_nxt.position;
    res.servo_enabled   = st_nxt.power_on;
    res.power_level     = st_nxt.power_on ? cfg.invert_power : ~cfg.invert_power;
    res.frog_level      = st_nxt.frog;
    res.motion_code     = st_nxt.motion;
    res.reported_active = ((st_nxt.motion == MOT_CLOSING) || (st_nxt.motion == MOT_THROWN))
                          ^ cfg.invert_operation;
    res.arrived         = arrived;
    res.request_taken   = taken;
  end

endmodule

`default_nettype wire

// ----- rtl/servo_turnout_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports
// input     in         in_valid, in_stall, in_command, in_requested_active
// result    out        out_valid, out_stall, out_servo_position .. out_request_taken
// config    in         cfg_wr_en, cfg_addr, cfg_wr_data
//
// Each transfer is handled combinationally; its result is valid in the next cycle.
// A new item can be taken every cycle unless a held result is stalled by out_stall.
// The turnout state and the result register update together on each input transfer.
// in_stall is high only while a result is held and out_stall is high.
// Synchronous active-low reset clears state, config and out_valid, not res_r.
module servo_turnout_sequencer import stsq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CmdW-1:0]     in_command,
  input  wire logic                in_requested_active,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [PosW-1:0]          out_servo_position,
  output logic                     out_servo_enabled,
  output logic                     out_power_level,
  output logic                     out_frog_level,
  output logic [1:0]               out_motion_code,
  output logic                     out_reported_active,
  output logic                     out_arrived,
  output logic                     out_request_taken,
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]  cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wr_data
);

  stsq_cfg_t    cfg_r;
  stsq_state_t  state_r;
  stsq_state_t  state_nxt;
  stsq_result_t res_r;
  stsq_result_t res_nxt;
  logic         out_valid_r;
  logic         in_xfer;

  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_START_POSITION:   cfg_r.start_position   <= cfg_wr_data;
        REG_END_POSITION:     cfg_r.end_position     <= cfg_wr_data;
        REG_STEP_INTERVAL:    cfg_r.step_interval    <= cfg_wr_data;
        REG_INVERT_OPERATION: cfg_r.invert_operation <= cfg_wr_data[0];
        REG_INVERT_POWER:     cfg_r.invert_power     <= cfg_wr_data[0];
        REG_INVERT_FROG:      cfg_r.invert_frog      <= cfg_wr_data[0];
        default: begin
        end
      endcase
    end
  end

  stsq_step u_step (
    .cmd              (in_command),
    .requested_active (in_requested_active),
    .cfg              (cfg_r),
    .st               (state_r),
    .st_nxt           (state_nxt),
    .res              (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{motion: MOT_CLOSED, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_servo_position  = res_r.servo_position;
  assign out_servo_enabled   = res_r.servo_enabled;
  assign out_power_level     = res_r.power_level;
  assign out_frog_level      = res_r.frog_level;
  assign out_motion_code     = res_r.motion_code;
  assign out_reported_active = res_r.reported_active;
  assign out_arrived         = res_r.arrived;
  assign out_request_taken   = res_r.request_taken;

  a_timer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.wait_timer <= WaitPowerOff)
    else $error("wait timer above power-off hold");

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("input transfer produced no result");

  a_held_result_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(res_r) && out_valid_r))
    else $error("held result changed");

  a_arrival_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.arrived) |->
      (res_r.motion_code == MOT_CLOSED || res_r.motion_code == MOT_THROWN))
    else $error("arrival reported while still moving");

  a_taken_powered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.request_taken) |-> res_r.servo_enabled)
    else $error("accepted request left servo unpowered");

endmodule

`default_nettype wire
